@@ src/stna_pkg.sv @@
// Shared constants, codes and control types for the sorted table neighbor average block.
package stna_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BEFORE = 2'd1,
    ST_NO_ABOVE  = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_RD_B   = 6'b000100,
    S_RD_U   = 6'b001000,
    S_SUM    = 6'b010000,
    S_PUT    = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic search;
    logic miss;
    logic rd_b;
    logic rd_u;
    logic sum;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_done;
    logic miss;
    logic out_free;
  } sts_t;

endpackage

@@ src/stna_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface stna_in_if import stna_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic [DATA_W-1:0]        energy;
  logic signed [DATA_W-1:0] real_corr;
  logic signed [DATA_W-1:0] imag_corr;

  modport source (output valid, func, energy, real_corr, imag_corr, input ready);
  modport sink   (input valid, func, energy, real_corr, imag_corr, output ready);
endinterface

interface stna_out_if import stna_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] real_avg;
  logic signed [DATA_W-1:0] imag_avg;
  logic [1:0]               status;

  modport source (output valid, real_avg, imag_avg, status, input ready);
  modport sink   (input valid, real_avg, imag_avg, status, output ready);
endinterface

@@ src/sorted_table_neighbor_average.sv @@
// Top level of the sorted table neighbor average block: controller, datapath and checks.
//
// Input channel in_ch (valid/ready) carries one item: func, energy, real_corr, imag_corr.
// func clear empties the table, append stores a row at the next free index (ascending
// energy order is the user's duty), query locates the energy with two binary searches.
// Result channel out_ch carries exactly one item per input item: real_avg, imag_avg and
// status. A query averages the corrections of the row just before the first row not below
// the energy and of the first row above it; edge cases return zeros with a flag.
// Clear, append and the unused selector go from idle to the put state, which loads their result
// into the output register once it is free. A query runs both searches interleaved on the single
// energy memory read port, at most one probe per cycle, alternating between them. It then
// fetches both neighbor rows in turn, adds them and loads the halved sum; when a flag ends the
// query early, it goes from the searches straight to the put state.
// Throughput: one item at a time; in_ch.ready is high only while the controller is idle.
// The result sits in an output register, so the next item is accepted while a result
// still waits; a stalled receiver holds the block only once a second result is ready.
// Reset clears the row count and the handshake state; the row memories are not cleared
// and need no clearing pass, since only rows written after the last clear or reset are ever used.
module sorted_table_neighbor_average import stna_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  stna_in_if.sink    in_ch,
  stna_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  stna_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  stna_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_func      (in_ch.func),
    .in_energy    (in_ch.energy),
    .in_real_corr (in_ch.real_corr),
    .in_imag_corr (in_ch.imag_corr),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_real_avg (out_ch.real_avg),
    .out_imag_avg (out_ch.imag_avg),
    .out_status   (out_ch.status)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted on back-to-back cycles");

  // No search may still be running while the block is idle.
  a_idle_search_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> sts.search_done)
    else $error("search still active while idle");

  // A result is loaded only when the output register is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwrote a pending item");
`endif

endmodule

@@ src/stna_ctrl.sv @@
// Controller state machine: sequences accept, search, row fetches and result hand-off.
module stna_ctrl import stna_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_ready,
  output cmd_t       cmd,
  input  sts_t       sts
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_func == FUNC_QUERY) ? S_SEARCH : S_PUT;
        end
      end
      S_SEARCH: begin
        if (sts.search_done) begin
          if (sts.miss) begin
            cmd.miss  = 1'b1;
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_RD_B;
          end
        end else begin
          cmd.search = 1'b1;
        end
      end
      S_RD_B: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_RD_U;
      end
      S_RD_U: begin
        cmd.rd_u  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/stna_dp.sv @@
// Datapath: row memories, interleaved dual binary search, averaging and output register.
module stna_dp import stna_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic [1:0]               in_func,
  input  logic [DATA_W-1:0]        in_energy,
  input  logic signed [DATA_W-1:0] in_real_corr,
  input  logic signed [DATA_W-1:0] in_imag_corr,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_real_avg,
  output logic signed [DATA_W-1:0] out_imag_avg,
  output logic [1:0]               out_status
);

  logic [DATA_W-1:0] energy_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] real_mem   [TABLE_DEPTH];
  logic [DATA_W-1:0] imag_mem   [TABLE_DEPTH];

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [DATA_W-1:0] key_r;
  // Search 0 finds the first row not below the key, search 1 the first row above it.
  logic [CNT_W-1:0]  lo_r [2];
  logic [CNT_W-1:0]  n_r  [2];
  logic [CNT_W-1:0]  lo_nxt [2];
  logic [CNT_W-1:0]  n_nxt  [2];
  logic              phase_r;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_sel_r;

  logic [DATA_W-1:0] energy_rd_r;
  logic [DATA_W-1:0] real_rd_r, imag_rd_r;
  logic [DATA_W-1:0] hold_real_r, hold_imag_r;

  logic signed [DATA_W-1:0] res_real_r, res_imag_r;
  status_t                  res_status_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_real_r, out_imag_r;
  logic [1:0]               out_status_r;

  logic              is_full;
  logic              do_append;
  logic [CNT_W-1:0]  iss_half, iss_mid;
  logic [IDX_W-1:0]  e_addr;
  logic              issue;
  logic [CNT_W-1:0]  upd_half, upd_mid;
  logic              advance;
  logic [CNT_W-1:0]  b_full;
  logic [IDX_W-1:0]  corr_addr;
  logic signed [DATA_W:0] sum_real, sum_imag;

  assign is_full   = (count_r == CNT_W'(TABLE_DEPTH));
  assign do_append = cmd.accept && (in_func == FUNC_APPEND) && !is_full;

  // Probe address for the search whose turn it is.
  assign iss_half = n_r[phase_r] >> 1;
  assign iss_mid  = lo_r[phase_r] + iss_half;
  assign e_addr   = iss_mid[IDX_W-1:0];
  assign issue    = cmd.search && (n_r[phase_r] != '0);

  // Update of the search whose probe data has just come back.
  assign upd_half = n_r[rd_sel_r] >> 1;
  assign upd_mid  = lo_r[rd_sel_r] + upd_half;
  assign advance  = rd_sel_r ? (energy_rd_r <= key_r) : (energy_rd_r < key_r);

  assign b_full    = lo_r[0] - CNT_W'(1);
  assign corr_addr = cmd.rd_b ? b_full[IDX_W-1:0] : lo_r[1][IDX_W-1:0];

  assign sum_real = {hold_real_r[DATA_W-1], hold_real_r} + {real_rd_r[DATA_W-1], real_rd_r};
  assign sum_imag = {hold_imag_r[DATA_W-1], hold_imag_r} + {imag_rd_r[DATA_W-1], imag_rd_r};

  always_comb begin
    count_nxt  = count_r;
    lo_nxt     = lo_r;
    n_nxt      = n_r;
    rd_vld_nxt = issue;
    if (cmd.accept) begin
      rd_vld_nxt = 1'b0;
      unique case (func_t'(in_func))
        FUNC_CLEAR:  count_nxt = '0;
        FUNC_APPEND: if (!is_full) count_nxt = count_r + CNT_W'(1);
        FUNC_QUERY: begin
          lo_nxt[0] = '0;
          lo_nxt[1] = '0;
          n_nxt[0]  = count_r;
          n_nxt[1]  = count_r;
        end
        default: count_nxt = count_r;
      endcase
    end else if (rd_vld_r) begin
      if (advance) begin
        lo_nxt[rd_sel_r] = upd_mid + CNT_W'(1);
        n_nxt[rd_sel_r]  = n_r[rd_sel_r] - upd_half - CNT_W'(1);
      end else begin
        n_nxt[rd_sel_r]  = upd_half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      lo_r[0]     <= '0;
      lo_r[1]     <= '0;
      n_r[0]      <= '0;
      n_r[1]      <= '0;
      phase_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      rd_sel_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      lo_r     <= lo_nxt;
      n_r      <= n_nxt;
      rd_vld_r <= rd_vld_nxt;
      rd_sel_r <= phase_r;
      if (cmd.accept) begin
        phase_r <= 1'b0;
      end else if (cmd.search) begin
        phase_r <= ~phase_r;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Row memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (do_append) begin
      energy_mem[count_r[IDX_W-1:0]] <= in_energy;
      real_mem[count_r[IDX_W-1:0]]   <= in_real_corr;
      imag_mem[count_r[IDX_W-1:0]]   <= in_imag_corr;
    end
    energy_rd_r <= energy_mem[e_addr];
    real_rd_r   <= real_mem[corr_addr];
    imag_rd_r   <= imag_mem[corr_addr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r        <= in_energy;
      res_real_r   <= '0;
      res_imag_r   <= '0;
      res_status_r <= (in_func == FUNC_APPEND && is_full) ? ST_FULL : ST_OK;
    end
    if (cmd.miss) begin
      res_status_r <= (lo_r[0] == '0) ? ST_NO_BEFORE : ST_NO_ABOVE;
    end
    if (cmd.rd_u) begin
      hold_real_r <= real_rd_r;
      hold_imag_r <= imag_rd_r;
    end
    if (cmd.sum) begin
      res_real_r   <= sum_real[DATA_W:1];
      res_imag_r   <= sum_imag[DATA_W:1];
      res_status_r <= ST_OK;
    end
    if (cmd.load) begin
      out_real_r   <= res_real_r;
      out_imag_r   <= res_imag_r;
      out_status_r <= res_status_r;
    end
  end

  assign sts.search_done = (n_r[0] == '0) && (n_r[1] == '0) && !rd_vld_r;
  assign sts.miss        = (lo_r[0] == '0) || (lo_r[1] == count_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_real_avg = out_real_r;
  assign out_imag_avg = out_imag_r;
  assign out_status   = out_status_r;

endmodule
